// ===== sv/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants for the button event detector.
// ----------------------------------------------------------------------------
package bed_pkg;

	// width of the timing registers and the countdown and since-read counters
	localparam int TIME_W = 16;
	localparam int SCAN_W = 8;
	localparam int FLAG_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	// flag bit positions
	localparam int FLAG_HOLD = 0;
	localparam int FLAG_DOWN = 1;
	localparam int FLAG_UP = 2;
	localparam int FLAG_SINGLE = 3;
	localparam int FLAG_DOUBLE = 4;
	localparam int FLAG_LONG = 5;
	localparam int FLAG_REPEAT = 6;

	// request opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TIME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 3'd4;

	// click state machine
	typedef enum logic [2:0] {
		CM_IDLE = 3'd0,
		CM_PRESSED = 3'd1,
		CM_WAIT_SECOND = 3'd2,
		CM_SECOND_HELD = 3'd3,
		CM_LONG = 3'd4
	} click_mode_t;

	typedef struct packed {
		logic op;
		logic pin_level;
		logic [FLAG_W-1:0] query_mask;
	} item_t;

	typedef struct packed {
		logic hit;
		logic [FLAG_W-1:0] flags;
	} res_t;

	typedef struct packed {
		logic [SCAN_W-1:0] scan_period;
		logic [TIME_W-1:0] hold_time;
		logic [TIME_W-1:0] double_time;
		logic [TIME_W-1:0] repeat_time;
		logic [TIME_W-1:0] stale_limit;
	} cfg_t;

endpackage

// ===== sv/bed_item_if.sv =====
// ----------------------------------------------------------------------------
// bed_item_if
// Request channel: tick or read requests into the detector.
// ----------------------------------------------------------------------------
interface bed_item_if;
	import bed_pkg::*;

	logic valid;
	logic ready;
	logic op;
	logic pin_level;
	logic [FLAG_W-1:0] query_mask;

	modport source (output valid, output op, output pin_level, output query_mask,
		input ready);
	modport sink (input valid, input op, input pin_level, input query_mask,
		output ready);

endinterface

// ===== sv/bed_result_if.sv =====
// ----------------------------------------------------------------------------
// bed_result_if
// Result channel: hit and flag snapshot, one per request.
// ----------------------------------------------------------------------------
interface bed_result_if;
	import bed_pkg::*;

	logic valid;
	logic ready;
	logic hit;
	logic [FLAG_W-1:0] flags;

	modport source (output valid, output hit, output flags, input ready);
	modport sink (input valid, input hit, input flags, output ready);

endinterface

// ===== sv/button_event_detector_top.sv =====
// ----------------------------------------------------------------------------
// button_event_detector_top
// Push-button event detector: debounced sampling, click state machine and
// flag register with masked read-and-clear.
// ----------------------------------------------------------------------------
// Each request is either a 1 ms tick carrying the raw active-low pin level or
// a read with a flag mask; every request yields exactly one result (hit and
// the flag register after the request). One request is taken per clock cycle
// while the result channel keeps up; a request is registered on entry,
// processed by single-cycle logic and its result is loaded into the output
// register once that register is free or its result is being taken.
// The output register lets a new request enter while a result waits to be
// taken. Configuration writes are only expected while no request is in flight.
module button_event_detector_top import bed_pkg::*; (
	input logic clk,
	input logic arst_n,
	bed_item_if.sink item_in,
	bed_result_if.source result_out,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic valid_s1;
	item_t item_s1;
	logic out_valid_q;
	res_t res_q;
	res_t core_res;
	logic accept_in;
	logic advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_period <= SCAN_W'(20);
			cfg_q.hold_time <= TIME_W'(1000);
			cfg_q.double_time <= TIME_W'(300);
			cfg_q.repeat_time <= TIME_W'(200);
			cfg_q.stale_limit <= TIME_W'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCAN_PERIOD: cfg_q.scan_period <= cfg_wdata[SCAN_W-1:0];
				CFG_HOLD_TIME: cfg_q.hold_time <= TIME_W'(cfg_wdata);
				CFG_DOUBLE_TIME: cfg_q.double_time <= TIME_W'(cfg_wdata);
				CFG_REPEAT_TIME: cfg_q.repeat_time <= TIME_W'(cfg_wdata);
				CFG_STALE_LIMIT: cfg_q.stale_limit <= TIME_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// handshake control
	assign advance = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign accept_in = item_in.valid && item_in.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1.op <= item_in.op;
			item_s1.pin_level <= item_in.pin_level;
			item_s1.query_mask <= item_in.query_mask;
		end
	end

	// detector state and update
	bed_core u_core (
		.clk (clk),
		.arst_n (arst_n),
		.step (advance),
		.item (item_s1),
		.cfg (cfg_q),
		.res (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= core_res;
	end

	assign result_out.valid = out_valid_q;
	assign result_out.hit = res_q.hit;
	assign result_out.flags = res_q.flags;

	// ticks never report a hit
	a_tick_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == OP_TICK |-> !core_res.hit)
		else $error("tick produced a hit");

	// a hit on a pure hold query leaves the hold flag set
	a_hold_query: assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_res.hit && item_s1.query_mask == FLAG_W'(1 << FLAG_HOLD)
		|-> core_res.flags[FLAG_HOLD])
		else $error("hold query cleared the hold flag");

	// a pending request is not dropped while the output stalls
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result_out.ready |=> valid_s1)
		else $error("request lost under output stall");

endmodule

// ===== sv/bed_core.sv =====
// ----------------------------------------------------------------------------
// bed_core
// Detector state and its single-cycle update for one request.
// ----------------------------------------------------------------------------
module bed_core import bed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic step,
	input item_t item,
	input cfg_t cfg,
	output res_t res
);

	logic [SCAN_W-1:0] scan_counter_q, scan_counter_d;
	logic level_now_q, level_now_d;
	logic level_before_q, level_before_d;
	click_mode_t click_mode_q, click_mode_d;
	logic [TIME_W-1:0] countdown_q, countdown_d;
	logic [TIME_W-1:0] since_read_q, since_read_d;
	logic [FLAG_W-1:0] event_flags_q, event_flags_d;

	logic [SCAN_W-1:0] scan_inc;
	logic [TIME_W-1:0] cd_dec;
	logic cd_zero;
	logic do_sample;
	logic pressed;
	logic [FLAG_W-1:0] sample_flags;
	logic [TIME_W-1:0] sample_cd;
	logic hit;

	// tick counters
	always_comb begin
		scan_inc = scan_counter_q + SCAN_W'(1);
		cd_dec = (countdown_q != '0) ? countdown_q - TIME_W'(1) : countdown_q;
		cd_zero = (cd_dec == '0);
		pressed = ~item.pin_level;
		do_sample = (item.op == OP_TICK) && (scan_inc >= cfg.scan_period);
	end

	// click machine next state, only meaningful on a sample
	always_comb begin
		case (click_mode_q)
			CM_IDLE: click_mode_d = pressed ? CM_PRESSED : CM_IDLE;
			CM_PRESSED: begin
				if (!pressed) click_mode_d = CM_WAIT_SECOND;
				else if (cd_zero) click_mode_d = CM_LONG;
				else click_mode_d = CM_PRESSED;
			end
			CM_WAIT_SECOND: begin
				if (pressed) click_mode_d = CM_SECOND_HELD;
				else if (cd_zero) click_mode_d = CM_IDLE;
				else click_mode_d = CM_WAIT_SECOND;
			end
			CM_SECOND_HELD: click_mode_d = pressed ? CM_SECOND_HELD : CM_IDLE;
			CM_LONG: click_mode_d = pressed ? CM_LONG : CM_IDLE;
			default: click_mode_d = CM_IDLE;
		endcase
	end

	// click machine outputs: flags raised and countdown reload on a sample
	always_comb begin
		sample_flags = event_flags_q;
		sample_flags[FLAG_HOLD] = pressed;
		if (pressed && !level_now_q) sample_flags[FLAG_DOWN] = 1'b1;
		if (!pressed && level_now_q) sample_flags[FLAG_UP] = 1'b1;
		sample_cd = cd_dec;
		case (click_mode_q)
			CM_IDLE: begin
				if (pressed) sample_cd = cfg.hold_time;
			end
			CM_PRESSED: begin
				if (!pressed) begin
					sample_cd = cfg.double_time;
				end else if (cd_zero) begin
					sample_cd = cfg.repeat_time;
					sample_flags[FLAG_LONG] = 1'b1;
				end
			end
			CM_WAIT_SECOND: begin
				if (pressed) sample_flags[FLAG_DOUBLE] = 1'b1;
				else if (cd_zero) sample_flags[FLAG_SINGLE] = 1'b1;
			end
			CM_LONG: begin
				if (pressed && cd_zero) begin
					sample_cd = cfg.repeat_time;
					sample_flags[FLAG_REPEAT] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// full step: tick or read
	always_comb begin
		scan_counter_d = scan_counter_q;
		level_now_d = level_now_q;
		level_before_d = level_before_q;
		countdown_d = countdown_q;
		since_read_d = since_read_q;
		event_flags_d = event_flags_q;
		hit = 1'b0;
		if (item.op == OP_TICK) begin
			if (since_read_q != '1) since_read_d = since_read_q + TIME_W'(1);
			countdown_d = cd_dec;
			scan_counter_d = scan_inc;
			if (do_sample) begin
				scan_counter_d = '0;
				level_before_d = level_now_q;
				level_now_d = pressed;
				event_flags_d = sample_flags;
				countdown_d = sample_cd;
			end
		end else begin
			since_read_d = '0;
			if (since_read_q < cfg.stale_limit) begin
				if ((event_flags_q & item.query_mask) != '0) begin
					hit = 1'b1;
					if (item.query_mask != FLAG_W'(1 << FLAG_HOLD))
						event_flags_d = event_flags_q & ~item.query_mask;
				end
			end else begin
				event_flags_d = '0;
			end
		end
		res.hit = hit;
		res.flags = event_flags_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_counter_q <= '0;
			level_now_q <= 1'b0;
			level_before_q <= 1'b0;
			click_mode_q <= CM_IDLE;
			countdown_q <= '0;
			since_read_q <= '0;
			event_flags_q <= '0;
		end else if (step) begin
			scan_counter_q <= scan_counter_d;
			level_now_q <= level_now_d;
			level_before_q <= level_before_d;
			if (do_sample) click_mode_q <= click_mode_d;
			countdown_q <= countdown_d;
			since_read_q <= since_read_d;
			event_flags_q <= event_flags_d;
		end
	end

endmodule

// ===== bench/button_event_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_detector_top_tb
// Self-checking bench for the push-button event detector. Tick and read
// requests go in over the request channel. A cycle-free model of the
// detector predicts hit and flags for every accepted request, and each
// result taken from the result channel is checked against the oldest
// prediction. Directed gestures, stale reads, unused register indexes and
// result back-pressure come first. Random press/release gestures under
// rotating timing settings follow.
// ----------------------------------------------------------------------------
module button_event_detector_top_tb;
	import bed_pkg::*;

	localparam logic PIN_PRESSED = 1'b0;
	localparam logic PIN_RELEASED = 1'b1;
	localparam logic [FLAG_W-1:0] MASK_NONE = '0;
	localparam logic [FLAG_W-1:0] MASK_ALL = '1;
	localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = FLAG_W'(1 << FLAG_HOLD);
	localparam logic [FLAG_W-1:0] MASK_SINGLE = FLAG_W'(1 << FLAG_SINGLE);
	localparam int MAX_WAIT = 18;
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 115;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bed_item_if req_if ();
	bed_result_if res_if ();

	button_event_detector_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(req_if),
		.result_out(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// detector model state and register copy
	cfg_t shadow_cfg;
	logic [SCAN_W-1:0] det_scan_cnt;
	logic det_pressed_now;
	logic det_pressed_prev;
	click_mode_t det_mode;
	logic [TIME_W-1:0] det_countdown;
	logic [TIME_W-1:0] det_since_read;
	logic [FLAG_W-1:0] det_flags;

	res_t flags_expected[$];
	int error_count = 0;
	int requests_sent = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int long_stall_cycles = 0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void note_error(string what);
		error_count++;
		if (error_count <= 10) begin
			$display("[%0t] %s", $time, what);
		end
	endfunction

	function automatic int draw_wait(bit enabled);
		return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	function automatic cfg_t make_cfg(int scan, int hold, int dbl, int rpt, int stale);
		cfg_t c;
		c.scan_period = SCAN_W'(scan);
		c.hold_time = TIME_W'(hold);
		c.double_time = TIME_W'(dbl);
		c.repeat_time = TIME_W'(rpt);
		c.stale_limit = TIME_W'(stale);
		return c;
	endfunction

	// one debounced pin sample: hold/edge flags, then the click machine
	function automatic void take_sample(logic pressed);
		det_pressed_prev = det_pressed_now;
		det_pressed_now = pressed;
		det_flags[FLAG_HOLD] = pressed;
		if (pressed && !det_pressed_prev) begin
			det_flags[FLAG_DOWN] = 1'b1;
		end
		if (!pressed && det_pressed_prev) begin
			det_flags[FLAG_UP] = 1'b1;
		end
		case (det_mode)
			CM_IDLE: begin
				if (pressed) begin
					det_countdown = shadow_cfg.hold_time;
					det_mode = CM_PRESSED;
				end
			end
			CM_PRESSED: begin
				if (!pressed) begin
					det_countdown = shadow_cfg.double_time;
					det_mode = CM_WAIT_SECOND;
				end else if (det_countdown == '0) begin
					det_countdown = shadow_cfg.repeat_time;
					det_flags[FLAG_LONG] = 1'b1;
					det_mode = CM_LONG;
				end
			end
			CM_WAIT_SECOND: begin
				if (pressed) begin
					det_flags[FLAG_DOUBLE] = 1'b1;
					det_mode = CM_SECOND_HELD;
				end else if (det_countdown == '0) begin
					det_flags[FLAG_SINGLE] = 1'b1;
					det_mode = CM_IDLE;
				end
			end
			CM_SECOND_HELD: begin
				if (!pressed) begin
					det_mode = CM_IDLE;
				end
			end
			CM_LONG: begin
				if (!pressed) begin
					det_mode = CM_IDLE;
				end else if (det_countdown == '0) begin
					det_countdown = shadow_cfg.repeat_time;
					det_flags[FLAG_REPEAT] = 1'b1;
				end
			end
			default: begin
				det_mode = CM_IDLE;
			end
		endcase
	endfunction

	// advance the model by one accepted request and return its result
	function automatic res_t advance_detector(logic op, logic pin, logic [FLAG_W-1:0] mask);
		res_t r;
		r.hit = 1'b0;
		if (op == OP_TICK) begin
			if (det_since_read != '1) begin
				det_since_read++;
			end
			if (det_countdown != '0) begin
				det_countdown--;
			end
			det_scan_cnt++;
			if (det_scan_cnt >= shadow_cfg.scan_period) begin
				det_scan_cnt = '0;
				take_sample(pin == PIN_PRESSED);
			end
		end else if (det_since_read < shadow_cfg.stale_limit) begin
			det_since_read = '0;
			if ((det_flags & mask) != '0) begin
				if (mask != MASK_HOLD_ONLY) begin
					det_flags &= ~mask;
				end
				r.hit = 1'b1;
			end
		end else begin
			// stale read drops everything
			det_flags = '0;
			det_since_read = '0;
		end
		r.flags = det_flags;
		return r;
	endfunction

	// send one request and record its predicted result on acceptance
	task automatic send_request(input logic op, input logic pin, input logic [FLAG_W-1:0] mask);
		int gap;
		gap = draw_wait(send_idle);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.pin_level <= pin;
		req_if.query_mask <= mask;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		flags_expected.push_back(advance_detector(op, pin, mask));
		requests_sent++;
	endtask

	task automatic tick(input logic pin);
		send_request(OP_TICK, pin, FLAG_W'($urandom_range(0, (1 << FLAG_W) - 1)));
	endtask

	task automatic read_flags(input logic [FLAG_W-1:0] mask);
		send_request(OP_READ, 1'($urandom_range(0, 1)), mask);
	endtask

	function automatic logic [FLAG_W-1:0] pick_read_mask();
		case ($urandom_range(0, 4))
			0: return MASK_NONE;
			1: return MASK_ALL;
			2: return MASK_HOLD_ONLY;
			3: return FLAG_W'(1 << $urandom_range(0, FLAG_W - 1));
			default: return FLAG_W'($urandom_range(0, (1 << FLAG_W) - 1));
		endcase
	endfunction

	// stop offering and wait until every result is back
	task automatic drain_requests();
		req_if.valid <= 1'b0;
		while (flags_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// raises the write strobe and waits for the write to be taken; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_SCAN_PERIOD: shadow_cfg.scan_period = data[SCAN_W-1:0];
			CFG_HOLD_TIME: shadow_cfg.hold_time = data[TIME_W-1:0];
			CFG_DOUBLE_TIME: shadow_cfg.double_time = data[TIME_W-1:0];
			CFG_REPEAT_TIME: shadow_cfg.repeat_time = data[TIME_W-1:0];
			CFG_STALE_LIMIT: shadow_cfg.stale_limit = data[TIME_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		drain_requests();
		write_reg(CFG_SCAN_PERIOD, CFG_DATA_W'(c.scan_period));
		write_reg(CFG_HOLD_TIME, CFG_DATA_W'(c.hold_time));
		write_reg(CFG_DOUBLE_TIME, CFG_DATA_W'(c.double_time));
		write_reg(CFG_REPEAT_TIME, CFG_DATA_W'(c.repeat_time));
		write_reg(CFG_STALE_LIMIT, CFG_DATA_W'(c.stale_limit));
		cfg_we <= 1'b0;
	endtask

	// directed single, double, long and repeat gestures, sampling every tick
	task automatic test_click_gestures();
		read_flags(MASK_NONE);
		load_config(make_cfg(0, 2, 2, 1, 1000));
		repeat (4) tick(PIN_PRESSED);
		read_flags(MASK_HOLD_ONLY);
		read_flags(MASK_ALL);
		tick(PIN_RELEASED);
		tick(PIN_PRESSED);
		repeat (3) tick(PIN_RELEASED);
		read_flags(MASK_SINGLE);
		tick(PIN_PRESSED);
		tick(PIN_RELEASED);
		tick(PIN_PRESSED);
		tick(PIN_RELEASED);
		read_flags(MASK_ALL);
	endtask

	// zero stale limit makes every read stale; then a short limit
	task automatic test_stale_reads();
		load_config(make_cfg(1, 0, 0, 0, 0));
		repeat (3) tick(PIN_PRESSED);
		read_flags(MASK_ALL);
		load_config(make_cfg(1, 0, 0, 0, 3));
		tick(PIN_RELEASED);
		read_flags(MASK_ALL);
		repeat (3) tick(PIN_PRESSED);
		read_flags(MASK_ALL);
	endtask

	// writes beyond the last register index must change nothing
	task automatic test_unused_registers();
		drain_requests();
		for (int idx = CFG_STALE_LIMIT + 1; idx < (1 << CFG_IDX_W); idx++) begin
			write_reg(CFG_IDX_W'(idx), '1);
		end
		cfg_we <= 1'b0;
		repeat (3) tick(PIN_PRESSED);
		read_flags(MASK_ALL);
	endtask

	// long result stall while requests keep coming, so the input backs up
	task automatic test_result_backpressure();
		drain_requests();
		send_idle = 1'b0;
		long_stall_cycles = 80;
		repeat (30) begin
			if ($urandom_range(0, 4) == 0) begin
				read_flags(pick_read_mask());
			end else begin
				tick(1'($urandom_range(0, 1)));
			end
		end
		send_idle = 1'b1;
	endtask

	// one tick of a gesture, with occasional bounce and interleaved reads
	task automatic gesture_tick(input logic pin);
		if ($urandom_range(0, 5) == 0) begin
			read_flags(pick_read_mask());
		end
		if ($urandom_range(0, 11) == 0) begin
			tick(~pin);
		end else begin
			tick(pin);
		end
	endtask

	// random press/release gestures under rotating timing settings
	task automatic test_random_gestures();
		int phase_start;
		int period;
		int press_len;
		int release_len;
		int stale;
		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 7))
				0: stale = 0;
				1: stale = 65535;
				default: stale = $urandom_range(4, 60);
			endcase
			load_config(make_cfg($urandom_range(0, 3), $urandom_range(0, 10),
				$urandom_range(0, 8), $urandom_range(0, 5), stale));
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			period = (shadow_cfg.scan_period == 0) ? 1 : int'(shadow_cfg.scan_period);
			phase_start = requests_sent;
			while (requests_sent - phase_start < PHASE_REQUESTS) begin
				if ($urandom_range(0, 9) == 0) begin
					// pure noise burst
					repeat (8) gesture_tick(1'($urandom_range(0, 1)));
				end else begin
					press_len = $urandom_range(1, (int'(shadow_cfg.hold_time) +
						3 * int'(shadow_cfg.repeat_time) + 3) * period);
					release_len = $urandom_range(1,
						(int'(shadow_cfg.double_time) + 3) * period);
					repeat (press_len) gesture_tick(PIN_PRESSED);
					repeat (release_len) gesture_tick(PIN_RELEASED);
				end
			end
		end
	endtask

	// result checker with random ready stalls
	initial begin
		int stall;
		res_t got;
		res_t want;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_stall_cycles > 0) begin
				stall = long_stall_cycles;
				long_stall_cycles = 0;
			end else begin
				stall = draw_wait(recv_idle);
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			got.hit = res_if.hit;
			got.flags = res_if.flags;
			if (flags_expected.size() == 0) begin
				note_error($sformatf("unexpected result hit=%0b flags=%07b",
					got.hit, got.flags));
			end else begin
				want = flags_expected.pop_front();
				if (got.hit !== want.hit || got.flags !== want.flags) begin
					note_error($sformatf("mismatch: expected hit=%0b flags=%07b, got hit=%0b flags=%07b",
						want.hit, want.flags, got.hit, got.flags));
				end
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.op = OP_TICK;
		req_if.pin_level = PIN_RELEASED;
		req_if.query_mask = MASK_NONE;
		shadow_cfg = make_cfg(20, 1000, 300, 200, 1000);
		det_scan_cnt = '0;
		det_pressed_now = 1'b0;
		det_pressed_prev = 1'b0;
		det_mode = CM_IDLE;
		det_countdown = '0;
		det_since_read = '0;
		det_flags = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_click_gestures();
		test_stale_reads();
		test_unused_registers();
		test_result_backpressure();
		test_random_gestures();
		drain_requests();

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
